// File: hw/rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
`default_nettype none

package lkv_pkg;

    localparam int KeyW  = 32;
    localparam int ValW  = 32;
    localparam int CapW  = 3;
    localparam int DataW = 32;
    localparam int PAddrW = 3;

    localparam int DEFAULT_ENTRIES = 4;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // word index of the capacity register (byte address 0)
    localparam logic CFG_CAP_WORD = 1'b0;

    localparam logic [CapW-1:0] CAP_RESET = 3'd4;
    localparam logic [ValW-1:0] MISS_DATA = '1;
    localparam logic [ValW-1:0] PUT_DATA  = '0;

    typedef struct packed {
        logic                   action;
        logic signed [KeyW-1:0] key;
        logic signed [ValW-1:0] value;
    } t_item;

    typedef struct packed {
        logic                   hit;
        logic signed [ValW-1:0] data;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/lkv_req_if.sv
// Request channel: get/put word with key and value.
`default_nettype none

interface lkv_req_if import lkv_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic signed [KeyW-1:0] key;
    logic signed [ValW-1:0] value;

    modport source (output valid, output action, output key, output value, input ready);
    modport sink   (input valid, input action, input key, input value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lkv_rsp_if.sv
// Response channel: hit flag and data word.
`default_nettype none

interface lkv_rsp_if import lkv_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic signed [ValW-1:0] data;

    modport source (output valid, output hit, output data, input ready);
    modport sink   (input valid, input hit, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lkv_cfg.sv
// APB-style configuration register block (capacity in use).
`default_nettype none

module lkv_cfg import lkv_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [PAddrW-1:0] paddr,
    input  wire logic [DataW-1:0]  pwdata,
    output logic      [DataW-1:0]  prdata,
    output logic                   pready,
    output logic      [CapW-1:0]   o_cap
);

    logic [CapW-1:0] r_cap;
    logic            cap_sel;
    logic            cap_wr;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[PAddrW-1] == CFG_CAP_WORD);
    assign cap_wr  = psel && penable && pwrite && pready && cap_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cap_wr) begin
            r_cap <= pwdata[CapW-1:0];
        end
    end

    assign prdata = cap_sel ? DataW'(r_cap) : '0;
    assign o_cap  = r_cap;

endmodule

`default_nettype wire

// File: hw/rtl/lkv_store.sv
// Entry store: parallel key match, per-entry recency ranks, LRU update.
`default_nettype none

module lkv_store import lkv_pkg::*; #(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire t_item           i_item,
    input  wire logic [CapW-1:0] i_cap,
    output t_result              o_result
);

    localparam int RankW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CntW  = $clog2(ENTRIES + 1);
    localparam int CmpW  = (CntW > CapW) ? CntW : CapW;

    logic [KeyW-1:0]  r_key  [ENTRIES];
    logic [ValW-1:0]  r_val  [ENTRIES];
    logic [RankW-1:0] r_rank [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [CntW-1:0]    r_count;

    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic [ENTRIES-1:0] free_oh;
    logic [ENTRIES-1:0] ins_vec;
    logic [ValW-1:0]    hit_val;
    logic [RankW-1:0]   hit_rank;
    logic [RankW-1:0]   lru_rank;
    logic [CapW-1:0]    cap_eff;
    logic               hit;
    logic               full;
    logic               is_put;

    assign is_put   = (i_item.action == ACT_PUT);
    // ranks among valid entries run 0..count-1, so the oldest holds count-1
    assign lru_rank = RankW'(r_count - CntW'(1));
    assign cap_eff  = (i_cap == '0) ? CapW'(1) : i_cap;
    assign full     = (CmpW'(r_count) >= CmpW'(cap_eff)) || (r_count == CntW'(ENTRIES));
    assign free_oh  = ~r_valid & (r_valid + ENTRIES'(1));

    always_comb begin
        hit_val  = '0;
        hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i]    = r_valid[i] && (r_key[i] == i_item.key);
            victim_vec[i] = r_valid[i] && (r_rank[i] == lru_rank);
            if (hit_vec[i]) begin
                hit_val  = hit_val | r_val[i];
                hit_rank = hit_rank | r_rank[i];
            end
        end
    end

    assign hit     = |hit_vec;
    assign ins_vec = full ? victim_vec : free_oh;

    always_comb begin
        o_result.hit = hit;
        if (is_put) begin
            o_result.data = PUT_DATA;
        end else if (hit) begin
            o_result.data = hit_val;
        end else begin
            o_result.data = MISS_DATA;
        end
    end

    // control state: valid bits, ranks, occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_fire) begin
            if (hit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (hit_vec[i]) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                        r_rank[i] <= r_rank[i] + RankW'(1);
                    end
                end
            end else if (is_put) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (ins_vec[i]) begin
                        r_rank[i]  <= '0;
                        r_valid[i] <= 1'b1;
                    end else if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + RankW'(1);
                    end
                end
                if (!full) begin
                    r_count <= r_count + CntW'(1);
                end
            end
        end
    end

    // key and value payload
    always_ff @(posedge i_clk) begin
        if (i_fire && is_put) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (hit_vec[i]) begin
                    r_val[i] <= i_item.value;
                end else if (!hit && ins_vec[i]) begin
                    r_key[i] <= i_item.key;
                    r_val[i] <= i_item.value;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: request/response staging and config.
`default_nettype none

// Fully associative key-value cache of ENTRIES pairs with least-recently-used
// replacement. One get or put word is taken every clock cycle while the
// response side is not stalled; each word passes through the request register
// and then the response register. All keys are compared in parallel and each
// entry holds a recency rank, so the whole lookup and LRU update is done
// combinationally between those two registers. A get hit returns the stored
// value, a get miss returns -1, a put returns 0; hit reports whether the key
// was present. The capacity register (byte address 0, reset 4) limits how
// many entries are filled before eviction; 0 is treated as 1 and values above
// ENTRIES as ENTRIES. Write it only while no request is in flight.
module lru_key_value_cache import lkv_pkg::*; #(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    lkv_req_if.sink                i_req,
    lkv_rsp_if.source              o_rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [PAddrW-1:0] paddr,
    input  wire logic [DataW-1:0]  pwdata,
    output logic      [DataW-1:0]  prdata,
    output logic                   pready
);

    logic [CapW-1:0] cap;
    logic            r_s1_valid;
    t_item           r_s1_item;
    logic            r_out_valid;
    t_result         r_out_result;
    logic            n_out_valid;
    t_result         result;
    logic            advance;
    logic            s1_fire;
    logic            in_fire;

    lkv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cap   (cap)
    );

    lkv_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_fire),
        .i_item   (r_s1_item),
        .i_cap    (cap),
        .o_result (result)
    );

    // the response register moves whenever it is empty or being drained
    assign advance     = !r_out_valid || o_rsp.ready;
    assign s1_fire     = r_s1_valid && advance;
    assign i_req.ready = !r_s1_valid || advance;
    assign in_fire     = i_req.valid && i_req.ready;
    assign n_out_valid = advance ? r_s1_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item.action <= i_req.action;
            r_s1_item.key    <= i_req.key;
            r_s1_item.value  <= i_req.value;
        end
        if (s1_fire) begin
            r_out_result <= result;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.hit   = r_out_result.hit;
    assign o_rsp.data  = r_out_result.data;

endmodule

`default_nettype wire

// File: sim/lru_key_value_cache_tb.sv
// Self-checking testbench for the LRU key-value cache: random get/put traffic, APB capacity writes.

module lru_key_value_cache_tb;
    import lkv_pkg::*;

    localparam int NUM_ENTRIES = DEFAULT_ENTRIES;
    localparam int NUM_PHASES  = 11;
    localparam int PHASE_WORDS = 120;
    localparam int HOLD_CYCLES = 100;
    localparam logic [PAddrW-1:0] CAP_ADDR = PAddrW'({CFG_CAP_WORD, 2'b00});

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PAddrW-1:0] paddr;
    logic [DataW-1:0]  pwdata;
    logic [DataW-1:0]  prdata;
    logic              pready;

    lkv_req_if req_ch ();
    lkv_rsp_if rsp_ch ();

    lru_key_value_cache #(.ENTRIES(NUM_ENTRIES)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the cache contents
    logic signed [KeyW-1:0] key_tab   [NUM_ENTRIES];
    logic signed [ValW-1:0] val_tab   [NUM_ENTRIES];
    logic                   valid_tab [NUM_ENTRIES];
    logic [1:0]             rank_tab  [NUM_ENTRIES];
    logic [CapW-1:0]        capacity_reg;

    t_item   pending_words[$];
    t_result expected_rsp[$];
    t_item   next_word;

    logic signed [KeyW-1:0] key_pool [8];
    logic [CapW-1:0]        cap_plan [NUM_PHASES];

    int  tx_gap, rx_gap;
    bit  tx_gaps_on, rx_gaps_on;
    logic rx_hold;
    int  n_errors, n_words, n_get_hits, n_put_updates, n_evictions;

    function automatic int pick_gap(input bit enable);
        int r;
        r = $urandom_range(0, 99);
        if (!enable || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void make_most_recent(input int idx);
        logic [1:0] old_rank;
        old_rank = rank_tab[idx];
        for (int j = 0; j < NUM_ENTRIES; j++)
            if (valid_tab[j] && j != idx && rank_tab[j] < old_rank)
                rank_tab[j] = rank_tab[j] + 2'd1;
        rank_tab[idx] = 2'd0;
    endfunction

    function automatic t_result cache_lookup(input t_item w);
        t_result         r;
        int              found, n_used, slot;
        logic [CapW-1:0] cap;
        logic [1:0]      worst;
        found  = -1;
        n_used = 0;
        slot   = -1;
        worst  = 2'd0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (valid_tab[i]) begin
                n_used++;
                if (found < 0 && key_tab[i] == w.key)
                    found = i;
            end
        end
        if (w.action == ACT_GET) begin
            if (found >= 0) begin
                make_most_recent(found);
                r.hit  = 1'b1;
                r.data = val_tab[found];
                n_get_hits++;
            end else begin
                r.hit  = 1'b0;
                r.data = MISS_DATA;
            end
            return r;
        end
        r.data = PUT_DATA;
        if (found >= 0) begin
            val_tab[found] = w.value;
            make_most_recent(found);
            r.hit = 1'b1;
            n_put_updates++;
            return r;
        end
        r.hit = 1'b0;
        cap = capacity_reg;
        if (cap == 0)
            cap = CapW'(1);
        if (cap > NUM_ENTRIES)
            cap = CapW'(NUM_ENTRIES);
        if (n_used >= cap) begin
            // evict the oldest valid entry and reuse its slot
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (valid_tab[i] && (slot < 0 || rank_tab[i] > worst)) begin
                    worst = rank_tab[i];
                    slot  = i;
                end
            end
            valid_tab[slot] = 1'b0;
            n_evictions++;
        end else begin
            for (int i = NUM_ENTRIES - 1; i >= 0; i--)
                if (!valid_tab[i])
                    slot = i;
        end
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (valid_tab[i])
                rank_tab[i] = rank_tab[i] + 2'd1;
        key_tab[slot]   = w.key;
        val_tab[slot]   = w.value;
        valid_tab[slot] = 1'b1;
        rank_tab[slot]  = 2'd0;
        return r;
    endfunction

    task automatic queue_word(input logic act, input logic [31:0] k, input logic [31:0] v);
        t_item w;
        w.action = act;
        w.key    = k;
        w.value  = v;
        pending_words.push_back(w);
    endtask

    task automatic queue_random(input int count);
        t_item w;
        for (int n = 0; n < count; n++) begin
            w.action = $urandom_range(0, 1) ? ACT_PUT : ACT_GET;
            w.key    = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 7)] : $urandom;
            w.value  = $urandom;
            pending_words.push_back(w);
        end
    endtask

    task automatic write_capacity(input logic [CapW-1:0] cap);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= DataW'(cap);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        capacity_reg = cap;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_words.size() != 0 || req_ch.valid || expected_rsp.size() != 0);
    endtask

    always #4 i_clk = ~i_clk;

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            tx_gap = 0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (tx_gap != 0) begin
                tx_gap--;
                req_ch.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                next_word = pending_words.pop_front();
                req_ch.valid  <= 1'b1;
                req_ch.action <= next_word.action;
                req_ch.key    <= next_word.key;
                req_ch.value  <= next_word.value;
                tx_gap = pick_gap(tx_gaps_on);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor: check first, then predict the word taken at this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsp.size() == 0) begin
                    $display("%0t: unexpected response, got hit %0b data %0d",
                             $time, rsp_ch.hit, rsp_ch.data);
                    n_errors++;
                end else begin
                    if (rsp_ch.hit !== expected_rsp[0].hit) begin
                        $display("%0t: hit mismatch, expected %0b, got %0b",
                                 $time, expected_rsp[0].hit, rsp_ch.hit);
                        n_errors++;
                    end
                    if (rsp_ch.data !== expected_rsp[0].data) begin
                        $display("%0t: data mismatch, expected %0d, got %0d",
                                 $time, expected_rsp[0].data, rsp_ch.data);
                        n_errors++;
                    end
                    void'(expected_rsp.pop_front());
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                expected_rsp.push_back(
                    cache_lookup(t_item'{req_ch.action, req_ch.key, req_ch.value}));
                n_words++;
            end
            if (rx_hold || rx_gap != 0) begin
                rsp_ch.ready <= 1'b0;
                if (rx_gap != 0)
                    rx_gap--;
            end else begin
                rsp_ch.ready <= 1'b1;
                rx_gap = pick_gap(rx_gaps_on);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("lru_key_value_cache regression: fail");
        $finish;
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_GET;
        req_ch.key    = '0;
        req_ch.value  = '0;
        rsp_ch.ready  = 1'b0;
        rx_hold      = 1'b0;
        tx_gaps_on   = 1'b1;
        rx_gaps_on   = 1'b1;
        n_errors     = 0;
        n_words      = 0;
        n_get_hits   = 0;
        n_put_updates = 0;
        n_evictions  = 0;
        capacity_reg = CAP_RESET;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            key_tab[i]   = '0;
            val_tab[i]   = '0;
            valid_tab[i] = 1'b0;
            rank_tab[i]  = 2'd0;
        end
        cap_plan = '{3'd1, 3'd0, 3'd2, 3'd7, 3'd3, 3'd4, 3'd6, 3'd1, 3'd5, 3'd2, 3'd4};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty miss, extreme keys and values, fill, update, evict
        queue_word(ACT_GET, 32'h0000_0000, 32'h0000_0000);
        queue_word(ACT_PUT, 32'h8000_0000, 32'h7fff_ffff);
        queue_word(ACT_PUT, 32'h7fff_ffff, 32'h8000_0000);
        queue_word(ACT_GET, 32'h8000_0000, 32'hffff_ffff);
        queue_word(ACT_GET, 32'h7fff_ffff, 32'h0000_0000);
        queue_word(ACT_PUT, 32'hffff_ffff, 32'hffff_ffff);
        queue_word(ACT_GET, 32'hffff_ffff, 32'h0000_0000);
        queue_word(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
        queue_word(ACT_GET, 32'h0000_0000, 32'h5a5a_5a5a);
        queue_word(ACT_PUT, 32'h1234_5678, 32'hdead_beef);
        queue_word(ACT_GET, 32'h8000_0000, 32'h0000_0000);
        queue_word(ACT_PUT, 32'h7fff_ffff, 32'h0bad_f00d);
        queue_word(ACT_GET, 32'h7fff_ffff, 32'ha5a5_a5a5);
        queue_word(ACT_PUT, 32'h0000_0001, 32'h0000_0002);
        queue_word(ACT_PUT, 32'h0000_0002, 32'h0000_0003);
        queue_word(ACT_GET, 32'hffff_ffff, 32'h0000_0000);
        queue_word(ACT_GET, 32'h1234_5678, 32'h0000_0000);
        queue_word(ACT_PUT, 32'h1234_5678, 32'h0000_0000);
        queue_word(ACT_GET, 32'h1234_5678, 32'h0000_0000);
        queue_word(ACT_GET, 32'h0000_0002, 32'h0000_0000);
        wait_idle();
        repeat (4) @(negedge i_clk);

        // first write drops capacity to 1 with the cache full
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_capacity(cap_plan[p]);
            key_pool[0] = 32'h8000_0000;
            key_pool[1] = 32'h7fff_ffff;
            key_pool[2] = 32'hffff_ffff;
            for (int i = 3; i < 8; i++)
                key_pool[i] = $urandom;
            tx_gaps_on = (p != 2 && p != 5);
            rx_gaps_on = (p != 2);
            queue_random(PHASE_WORDS);
            if (p == 5) begin
                // sink holds off while the source keeps offering words
                @(posedge i_clk);
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            wait_idle();
            repeat (4) @(negedge i_clk);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("Ran %0d words over %0d capacity settings (0 to 7, incl. shrink while full)",
                 n_words, NUM_PHASES + 1);
        $display("Saw %0d get hits, %0d put updates and %0d evictions",
                 n_get_hits, n_put_updates, n_evictions);
        if (n_errors == 0 && expected_rsp.size() == 0)
            $display("lru_key_value_cache regression: pass");
        else
            $display("lru_key_value_cache regression: fail");
        $finish;
    end

endmodule
